// File: rtl/nfa_anchored_longest_match_core_defines.svh
// Assertion macros for the anchored NFA match core.
// No dependencies; included by the files that assert.
`ifndef NFA_ANCHORED_LONGEST_MATCH_CORE_DEFINES_SVH
`define NFA_ANCHORED_LONGEST_MATCH_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define NALM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NALM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define NALM_ASSERT(label, prop, msg)
`define NALM_ASSERT_IMP(label, ante, cons, msg)
`endif
`endif

// File: rtl/nalm_pkg.sv
// Shared types and constants for the anchored NFA match core.
// No dependencies.
`default_nettype none
package nalm_pkg;
  localparam int NUM_STATES  = 64;
  localparam int LENGTH_BITS = 16;
  localparam int IDX_W       = $clog2(NUM_STATES);
  localparam int LINK_W      = 7;
  localparam int CLASS_DEPTH = NUM_STATES * 4;
  localparam int CLASS_AW    = $clog2(CLASS_DEPTH);

  localparam logic [1:0] CMD_LOAD_ENTRY = 2'd0;
  localparam logic [1:0] CMD_LOAD_CLASS = 2'd1;
  localparam logic [1:0] CMD_TEXT       = 2'd2;

  localparam logic [1:0] KIND_EPS    = 2'd0;
  localparam logic [1:0] KIND_LIT    = 2'd1;
  localparam logic [1:0] KIND_CLASS  = 2'd2;

  localparam logic [0:0] REG_START  = 1'b0;
  localparam logic [0:0] REG_ACCEPT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP_RD, ST_STEP, ST_CLOSE, ST_FINISH, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// File: rtl/nfa_anchored_longest_match_core.sv
// Anchored longest-match Thompson NFA engine, top level.
// Depends on nalm_pkg and nfa_anchored_longest_match_core_defines.svh.
//
//  channel | ports                          | direction
//  in      | in_valid/in_ready, in_* fields | item in
//  out     | out_valid/out_ready, out_*     | result out
//  cfg     | psel..pready, start/accept regs | APB register port
//
// A text byte walks the NFA one state per cycle through one shared state
// scan unit: a table read, a step pass over all NUM_STATES states, then
// closure passes until a pass adds nothing, then a finish step and the
// output step. A later byte while the set is dead goes straight to output.
// A first byte runs a table read and closure passes for the start set before
// the step; if that set is empty it goes straight to output. The result
// waits in an output register; a new item is taken only after it leaves.
// No clearing pass after reset.
`default_nettype none
`include "nfa_anchored_longest_match_core_defines.svh"
module nfa_anchored_longest_match_core
  import nalm_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [1:0]           in_command,
  input  wire logic [5:0]           in_entry_index,
  input  wire logic [1:0]           in_entry_kind,
  input  wire logic [7:0]           in_entry_char,
  input  wire logic [6:0]           in_link_one,
  input  wire logic [6:0]           in_link_two,
  input  wire logic [1:0]           in_word_select,
  input  wire logic [63:0]          in_bitmap_word,
  input  wire logic [7:0]           in_text_byte,
  input  wire logic                 in_first,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      logic                 out_matched,
  output      logic [15:0]          out_match_length,
  output      logic                 out_dead,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output      logic [31:0]          prdata,
  output      logic                 pready
);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  logic [1:0]        kind_mem [NUM_STATES];
  logic [7:0]        char_mem [NUM_STATES];
  logic [LINK_W-1:0] l1_mem   [NUM_STATES];
  logic [LINK_W-1:0] l2_mem   [NUM_STATES];
  logic [63:0]       class_mem [CLASS_DEPTH];

  state_t state_r, state_nxt;
  logic [5:0] start_r, accept_r;
  logic [NUM_STATES-1:0] act_r, act_nxt, nxt_r, nxt_nxt;
  logic [IDX_W:0] cnt_r, cnt_nxt;
  logic chg_r, chg_nxt, pre_r, pre_nxt;
  logic [LENGTH_BITS-1:0] run_r, run_nxt, best_r, best_nxt;
  logic found_r, found_nxt, dead_r, dead_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic ov_r, ov_nxt;

  // registered table read for the scanned state
  logic [1:0] rk_r; logic [7:0] rc_r; logic [LINK_W-1:0] r1_r, r2_r;
  logic [63:0] rcl_r;
  logic [IDX_W-1:0] ri_r;

  logic in_xfer, out_xfer, cfg_wr;
  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign in_ready = (state_r == ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_matched = found_r;
  assign out_match_length = best_r[15:0];
  assign out_dead = dead_r;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_START:  prdata[5:0] = start_r;
      REG_ACCEPT: prdata[5:0] = accept_r;
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r  <= 6'd0;
      accept_r <= 6'd1;
    end else if (cfg_wr && paddr[1:0] == 2'd0) begin
      if (paddr[2] == REG_START)  start_r  <= pwdata[5:0];
      if (paddr[2] == REG_ACCEPT) accept_r <= pwdata[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_command == CMD_LOAD_ENTRY) begin
      kind_mem[in_entry_index[IDX_W-1:0]] <= in_entry_kind;
      char_mem[in_entry_index[IDX_W-1:0]] <= in_entry_char;
      l1_mem[in_entry_index[IDX_W-1:0]]   <= in_link_one;
      l2_mem[in_entry_index[IDX_W-1:0]]   <= in_link_two;
    end
    if (in_xfer && in_command == CMD_LOAD_CLASS)
      class_mem[{in_entry_index[IDX_W-1:0], in_word_select}] <= in_bitmap_word;
  end

  // read port: addressed by scan counter, data lands next cycle
  logic [IDX_W-1:0] ra;
  assign ra = cnt_r[IDX_W-1:0];
  always_ff @(posedge clk) begin
    rk_r  <= kind_mem[ra];
    rc_r  <= char_mem[ra];
    r1_r  <= l1_mem[ra];
    r2_r  <= l2_mem[ra];
    rcl_r <= class_mem[{ra, byte_r[7:6]}];
    ri_r  <= ra;
  end

  // shared scan: one state per cycle, adds links into nxt
  logic hit, eps, scan, close_add, pass_chg;
  logic [NUM_STATES-1:0] addm;
  always_comb begin
    hit = 1'b0;
    unique case (rk_r)
      KIND_LIT:   hit = (rc_r == byte_r);
      KIND_CLASS: hit = rcl_r[byte_r[5:0]];
      default:    hit = 1'b0;
    endcase
    eps = (rk_r == KIND_EPS);
    addm = '0;
    if (r1_r < LINK_W'(NUM_STATES)) addm[r1_r[IDX_W-1:0]] = 1'b1;
    if (r2_r < LINK_W'(NUM_STATES) && eps) addm[r2_r[IDX_W-1:0]] = 1'b1;
    close_add = (cnt_r != '0) && nxt_r[ri_r] && eps && ((addm & ~nxt_r) != '0);
    pass_chg = chg_r || close_add;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:
        if (in_xfer && in_command == CMD_TEXT) begin
          if (in_first || !dead_r) state_nxt = ST_STEP_RD;
          else state_nxt = ST_OUT;
        end
      ST_STEP_RD: state_nxt = pre_r ? ST_CLOSE : ST_STEP;
      ST_STEP:  if (cnt_r == (IDX_W+1)'(NUM_STATES)) state_nxt = ST_CLOSE;
      ST_CLOSE:
        // repeat the pass while it still adds states
        if (cnt_r == (IDX_W+1)'(NUM_STATES) && !pass_chg) begin
          if (!pre_r) state_nxt = ST_FINISH;
          else if (nxt_r == '0) state_nxt = ST_OUT;
          else state_nxt = ST_STEP_RD;
        end
      ST_FINISH: state_nxt = ST_OUT;
      ST_OUT:   state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    act_nxt = act_r; nxt_nxt = nxt_r; cnt_nxt = cnt_r; chg_nxt = chg_r;
    pre_nxt = pre_r; run_nxt = run_r; best_nxt = best_r; found_nxt = found_r;
    dead_nxt = dead_r; byte_nxt = byte_r; ov_nxt = ov_r;
    scan = 1'b0;
    if (out_xfer) ov_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE:
        if (in_xfer && in_command == CMD_TEXT) begin
          byte_nxt = in_text_byte;
          cnt_nxt = '0; chg_nxt = 1'b0;
          if (in_first) begin
            pre_nxt = 1'b1;
            nxt_nxt = '0;
            nxt_nxt[start_r[IDX_W-1:0]] = 1'b1;
            run_nxt = '0; best_nxt = '0; found_nxt = 1'b0;
          end else begin
            pre_nxt = 1'b0;
            nxt_nxt = '0;
          end
        end
      ST_STEP_RD: cnt_nxt = (IDX_W+1)'(1);
      ST_STEP: begin
        // step reads act_r at ri_r
        if (act_r[ri_r] && hit && r1_r < LINK_W'(NUM_STATES))
          nxt_nxt[r1_r[IDX_W-1:0]] = 1'b1;
        if (cnt_r == (IDX_W+1)'(NUM_STATES)) cnt_nxt = '0;
        else cnt_nxt = cnt_r + 1'b1;
      end
      ST_CLOSE: begin
        scan = 1'b1;
        if (close_add) nxt_nxt = nxt_r | addm;
        if (cnt_r == (IDX_W+1)'(NUM_STATES)) begin
          cnt_nxt = '0;
          chg_nxt = 1'b0;
          if (!pass_chg) begin
            act_nxt = nxt_r;
            if (pre_r) begin
              run_nxt = '0;
              if (nxt_r[accept_r[IDX_W-1:0]]) begin
                found_nxt = 1'b1; best_nxt = '0;
              end
              if (nxt_r == '0) begin
                dead_nxt = 1'b1;
              end else begin
                dead_nxt = 1'b0; pre_nxt = 1'b0; nxt_nxt = '0;
              end
            end
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          if (close_add) chg_nxt = 1'b1;
        end
      end
      ST_FINISH: begin
        if (run_r != LEN_MAX) run_nxt = run_r + 1'b1;
        if (act_r[accept_r[IDX_W-1:0]]) begin
          found_nxt = 1'b1;
          best_nxt = (run_r != LEN_MAX) ? run_r + 1'b1 : run_r;
        end
        dead_nxt = (act_r == '0);
      end
      ST_OUT: ov_nxt = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE; act_r <= '0; run_r <= '0; best_r <= '0;
      found_r <= 1'b0; dead_r <= 1'b1; ov_r <= 1'b0; cnt_r <= '0;
      chg_r <= 1'b0; pre_r <= 1'b0;
    end else begin
      state_r <= state_nxt; act_r <= act_nxt; run_r <= run_nxt; best_r <= best_nxt;
      found_r <= found_nxt; dead_r <= dead_nxt; ov_r <= ov_nxt; cnt_r <= cnt_nxt;
      chg_r <= chg_nxt; pre_r <= pre_nxt;
    end
  end

  always_ff @(posedge clk) begin
    nxt_r  <= nxt_nxt;
    byte_r <= byte_nxt;
  end

  `NALM_ASSERT_IMP(a_busy_not_ready, state_r != ST_IDLE, !in_ready, "ready while busy")
  `NALM_ASSERT_IMP(a_out_hold, out_valid && !out_ready, ##1 out_valid, "result dropped")
  `NALM_ASSERT_IMP(a_dead_empty, state_r == ST_IDLE && !dead_r, act_r != '0, "live but empty")
  `NALM_ASSERT_IMP(a_scan_close, scan, state_r == ST_CLOSE, "scan outside closure")
endmodule
`default_nettype wire

// File: sim/tb_nfa_anchored_longest_match_core.sv
// Testbench for nfa_anchored_longest_match_core: table fill, directed rows, then random
// NFA loads and text with a built-in predictor; depends on nalm_pkg and the core RTL.
`default_nettype none
module tb_nfa_anchored_longest_match_core;
  import nalm_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam logic [1:0] KIND_ACCEPT = 2'd3;
  localparam int RUN_LIMIT = 200_000_000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [5:0]  idx;
    logic [1:0]  kind;
    logic [7:0]  ch;
    logic [6:0]  l1;
    logic [6:0]  l2;
    logic [1:0]  ws;
    logic [63:0] word;
    logic [7:0]  tbyte;
    logic        first;
  } nfa_item_t;

  typedef struct packed {
    logic        matched;
    logic [15:0] len;
    logic        dead;
  } match_status_t;

  typedef struct packed {
    nfa_item_t     item;
    logic          typed;
    match_status_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic [5:0] in_entry_index;
  logic [1:0] in_entry_kind;
  logic [7:0] in_entry_char;
  logic [6:0] in_link_one;
  logic [6:0] in_link_two;
  logic [1:0] in_word_select;
  logic [63:0] in_bitmap_word;
  logic [7:0] in_text_byte;
  logic in_first;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_matched;
  logic [15:0] out_match_length;
  logic out_dead;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  always #4 clk = ~clk;

  nfa_anchored_longest_match_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_entry_index(in_entry_index),
    .in_entry_kind(in_entry_kind), .in_entry_char(in_entry_char),
    .in_link_one(in_link_one), .in_link_two(in_link_two),
    .in_word_select(in_word_select), .in_bitmap_word(in_bitmap_word),
    .in_text_byte(in_text_byte), .in_first(in_first),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_matched(out_matched), .out_match_length(out_match_length),
    .out_dead(out_dead),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state
  logic [1:0]  kind_mem [0:63];
  logic [7:0]  char_mem [0:63];
  logic [6:0]  link1_mem [0:63];
  logic [6:0]  link2_mem [0:63];
  logic [63:0] class_mem [0:255];
  logic [63:0] live_set = '0;
  logic [15:0] run_len = '0;
  logic [15:0] best_len = '0;
  logic        seen_accept = 1'b0;
  logic        set_dead = 1'b1;
  logic [5:0]  start_r = 6'd0;
  logic [5:0]  accept_r = 6'd1;

  match_status_t pending_status [$];
  int errors = 0;
  int burst_left = 0;
  logic hold_trigger = 1'b0;

  function automatic logic [63:0] eps_close(input logic [63:0] s);
    bit grow;
    logic [6:0] lk;
    grow = 1'b1;
    while (grow) begin
      grow = 1'b0;
      for (int i = 0; i < 64; i++) begin
        if (s[i] && kind_mem[i] == KIND_EPS) begin
          for (int j = 0; j < 2; j++) begin
            lk = (j == 0) ? link1_mem[i] : link2_mem[i];
            if (lk < 7'd64 && !s[lk[5:0]]) begin
              s[lk[5:0]] = 1'b1;
              grow = 1'b1;
            end
          end
        end
      end
    end
    return s;
  endfunction

  function automatic void note_accept();
    if (live_set[accept_r]) begin
      seen_accept = 1'b1;
      best_len = run_len;
    end
  endfunction

  // Advance the predicted engine by one item; return 1 where a status is due.
  function automatic bit nfa_step(input nfa_item_t it, output match_status_t st);
    logic [63:0] nxt;
    logic [7:0] idx8;
    bit hit;
    st = '0;
    if (it.cmd == CMD_LOAD_ENTRY) begin
      kind_mem[it.idx] = it.kind;
      char_mem[it.idx] = it.ch;
      link1_mem[it.idx] = it.l1;
      link2_mem[it.idx] = it.l2;
      return 1'b0;
    end
    if (it.cmd == CMD_LOAD_CLASS) begin
      class_mem[{it.idx, it.ws}] = it.word;
      return 1'b0;
    end
    if (it.cmd != CMD_TEXT) return 1'b0;
    if (it.first) begin
      live_set = eps_close(64'd1 << start_r);
      run_len = '0;
      best_len = '0;
      seen_accept = 1'b0;
      note_accept();
      set_dead = (live_set == '0);
    end
    if (!set_dead) begin
      nxt = '0;
      for (int i = 0; i < 64; i++) begin
        hit = 1'b0;
        if (live_set[i]) begin
          idx8 = {i[5:0], it.tbyte[7:6]};
          if (kind_mem[i] == KIND_LIT) hit = (char_mem[i] == it.tbyte);
          else if (kind_mem[i] == KIND_CLASS) hit = class_mem[idx8][it.tbyte[5:0]];
          if (hit && link1_mem[i] < 7'd64) nxt[link1_mem[i][5:0]] = 1'b1;
        end
      end
      live_set = eps_close(nxt);
      if (run_len != 16'hFFFF) run_len++;
      note_accept();
      set_dead = (live_set == '0);
    end
    st.matched = seen_accept;
    st.len = best_len;
    st.dead = set_dead;
    return 1'b1;
  endfunction

  // Offer one item in bursts with random gaps; record the prediction on transfer.
  task automatic send_item(input nfa_item_t it, input bit typed, input match_status_t want);
    int gap;
    match_status_t st;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    in_valid <= 1'b1;
    in_command <= it.cmd;
    in_entry_index <= it.idx;
    in_entry_kind <= it.kind;
    in_entry_char <= it.ch;
    in_link_one <= it.l1;
    in_link_two <= it.l2;
    in_word_select <= it.ws;
    in_bitmap_word <= it.word;
    in_text_byte <= it.tbyte;
    in_first <= it.first;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (nfa_step(it, st)) pending_status.push_back(typed ? want : st);
  endtask

  task automatic cfg_write(input logic [0:0] reg_sel, input logic [5:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_sel, 2'b00};
    pwdata <= {26'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_START) start_r = value;
    else accept_r = value;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    // loads leave no status; give the last one time to land
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1, 2: return 8'h61;
      3, 4, 5: return 8'h62;
      6, 7:    return 8'h63;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [6:0] pick_link();
    if ($urandom_range(0, 7) == 0) return 7'($urandom_range(64, 127));
    return 7'($urandom_range(0, 63));
  endfunction

  function automatic nfa_item_t rand_entry(input logic [5:0] idx);
    nfa_item_t it;
    it = '0;
    it.cmd = CMD_LOAD_ENTRY;
    it.idx = idx;
    it.kind = 2'($urandom);
    it.ch = pick_byte();
    it.l1 = pick_link();
    it.l2 = pick_link();
    it.ws = 2'($urandom);
    it.word = {$urandom, $urandom};
    it.tbyte = 8'($urandom);
    it.first = 1'($urandom);
    return it;
  endfunction

  function automatic nfa_item_t rand_item();
    nfa_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it = rand_entry(6'($urandom));
    if (r < 70) begin
      it.cmd = CMD_TEXT;
      it.tbyte = pick_byte();
      it.first = ($urandom_range(0, 6) == 0);
    end else if (r < 88) begin
      it.cmd = CMD_LOAD_ENTRY;
    end else if (r < 97) begin
      it.cmd = CMD_LOAD_CLASS;
      case ($urandom_range(0, 3))
        0: it.word = '0;
        1: it.word = '1;
        default: it.word = {$urandom, $urandom};
      endcase
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // Directed rows: "ab*" with accept at 1, then class, dead and empty-step cases.
  dir_row_t dir_rows [0:20] = '{
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b1, '{1'b0, 16'd0, 1'b1}},
    '{'{CMD_UNUSED, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_LOAD_ENTRY, 6'd0, KIND_LIT, 8'h61, 7'd2, 7'd64, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_LOAD_ENTRY, 6'd2, KIND_EPS, 8'h00, 7'd3, 7'd1, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_LOAD_ENTRY, 6'd3, KIND_LIT, 8'h62, 7'd2, 7'd64, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_LOAD_ENTRY, 6'd1, KIND_ACCEPT, 8'hFF, 7'd127, 7'd127, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h61, 1'b1},
      1'b1, '{1'b1, 16'd1, 1'b0}},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h62, 1'b0},
      1'b1, '{1'b1, 16'd2, 1'b0}},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h62, 1'b0},
      1'b1, '{1'b1, 16'd3, 1'b0}},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h78, 1'b0},
      1'b1, '{1'b1, 16'd3, 1'b1}},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h62, 1'b0},
      1'b1, '{1'b1, 16'd3, 1'b1}},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h62, 1'b1},
      1'b1, '{1'b0, 16'd0, 1'b1}},
    '{'{CMD_LOAD_ENTRY, 6'd0, KIND_CLASS, 8'h00, 7'd1, 7'd64, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_LOAD_CLASS, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd3, '1, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_LOAD_CLASS, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'hFF, 1'b1},
      1'b1, '{1'b1, 16'd1, 1'b0}},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b1, '{1'b1, 16'd1, 1'b1}},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h00, 1'b1},
      1'b1, '{1'b0, 16'd0, 1'b1}},
    '{'{CMD_LOAD_ENTRY, 6'd0, KIND_EPS, 8'h00, 7'd1, 7'd127, 2'd0, 64'd0, 8'h00, 1'b0},
      1'b0, '0},
    '{'{CMD_TEXT, 6'd0, 2'd0, 8'h00, 7'd0, 7'd0, 2'd0, 64'd0, 8'h3F, 1'b1},
      1'b1, '{1'b1, 16'd0, 1'b1}},
    '{'{CMD_LOAD_CLASS, 6'd63, 2'd0, 8'h00, 7'd0, 7'd0, 2'd2, 64'd0, 8'h00, 1'b0},
      1'b0, '0}
  };

  // Receiver: stall pattern of its own, plus one long hold-off to fill the block.
  int recv_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    match_status_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: status expected none actual m=%0b len=%0d dead=%0b", $time,
                 out_matched, out_match_length, out_dead);
      end else begin
        want = pending_status.pop_front();
        if (out_matched !== want.matched) begin
          errors++;
          $display("%0t: matched expected %0b actual %0b", $time, want.matched, out_matched);
        end
        if (out_match_length !== want.len) begin
          errors++;
          $display("%0t: match_length expected %0d actual %0d", $time, want.len,
                   out_match_length);
        end
        if (out_dead !== want.dead) begin
          errors++;
          $display("%0t: dead expected %0b actual %0b", $time, want.dead, out_dead);
        end
      end
    end
    if (hold_trigger && !hold_done) begin
      hold_left = 2000;
      hold_done = 1'b1;
    end
    if (mode_left == 0) begin
      recv_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (recv_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  initial begin
    nfa_item_t it;
    int phase_items;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_LOAD_ENTRY;
    in_entry_index = '0;
    in_entry_kind = KIND_EPS;
    in_entry_char = '0;
    in_link_one = '0;
    in_link_two = '0;
    in_word_select = '0;
    in_bitmap_word = '0;
    in_text_byte = '0;
    in_first = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // write the whole table first so no text step can read an unwritten entry
    for (int i = 0; i < 64; i++) send_item(rand_entry(6'(i)), 1'b0, '0);
    for (int i = 0; i < 256; i++) begin
      it = rand_entry(6'(i >> 2));
      it.cmd = CMD_LOAD_CLASS;
      it.ws = 2'(i);
      send_item(it, 1'b0, '0);
    end

    foreach (dir_rows[r]) send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].want);

    for (int ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: begin cfg_write(REG_START, 6'd0);  cfg_write(REG_ACCEPT, 6'd63); end
        1: begin cfg_write(REG_START, 6'd63); cfg_write(REG_ACCEPT, 6'd0);  end
        default: begin
          cfg_write(REG_START, 6'($urandom));
          cfg_write(REG_ACCEPT, 6'($urandom));
        end
      endcase
      if (ph == 2) hold_trigger <= 1'b1;
      phase_items = $urandom_range(85, 100);
      for (int n = 0; n < phase_items; n++) send_item(rand_item(), 1'b0, '0);
    end

    drain();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #RUN_LIMIT;
    $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
+incdir+rtl
rtl/nalm_pkg.sv
rtl/nfa_anchored_longest_match_core.sv
sim/tb_nfa_anchored_longest_match_core.sv
